>>> hw/rtl/cppwm_pkg.sv
// Shared types, constants and the duty-to-current map for the pilot PWM decoder.
package cppwm_pkg;

    // field and state widths
    localparam int W_OP    = 1;
    localparam int W_TIME  = 10;
    localparam int W_LEVEL = 1;
    localparam int W_CUR   = 7;
    localparam int W_WRAP  = 16;
    localparam int W_FALL  = 26;
    // divider: numerator is 100 * high time (high time below 4096)
    localparam int W_NUM   = 19;
    localparam int W_PER   = 11;
    localparam int W_QUO   = 9;

    // request codes
    localparam logic OP_WRAP    = 1'b0;
    localparam logic OP_EDGE    = 1'b1;
    localparam logic LEVEL_FALL = 1'b0;
    localparam logic LEVEL_RISE = 1'b1;

    // timing constants
    localparam logic [9:0]        WRAP_COUNTS     = 10'd1000;
    localparam logic [W_PER-1:0]  PERIOD_MIN_EXCL = 11'd900;
    localparam logic [W_PER-1:0]  PERIOD_MAX      = 11'd1100;
    localparam logic [6:0]        DUTY_SCALE      = 7'd100;
    localparam logic [W_CUR-1:0]  DEFAULT_CURRENT = 7'd6;
    localparam logic [W_CUR-1:0]  TOP_CURRENT     = 7'd80;
    localparam logic [W_WRAP-1:0] TIMEOUT_RESET   = 16'd500;
    localparam logic [W_QUO-1:0]  BAND_OFFSET     = 9'd64;
    // 205 / 1024 stands in for 1 / 5 on values below 1024
    localparam logic [16:0]       RECIP_FIVE      = 17'd205;

    typedef struct packed {
        logic              operation;
        logic [W_TIME-1:0] capture_time;
        logic              pin_level;
    } t_in_req;

    typedef struct packed {
        logic [W_CUR-1:0] amp_limit;
        logic             current_changed;
    } t_out_req;

    typedef struct packed {
        logic             start;
        logic [W_NUM-1:0] num;
        logic [W_PER-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [W_QUO-1:0] quotient;
    } t_div_stat;

    // Standard duty bands, duty in whole percent (0..100)
    function automatic logic [W_CUR-1:0] duty_to_current(input logic [W_QUO-1:0] duty);
        logic [8:0]  y;
        logic [16:0] p;
        logic [5:0]  dm;
        logic [7:0]  b;
        y  = 9'(duty[6:0]) * 9'd3;
        p  = 17'(y) * RECIP_FIVE;
        dm = 6'(duty - BAND_OFFSET);
        b  = 8'(dm) * 8'd5;
        if (duty < 9'd3) begin
            return '0;
        end else if (duty <= 9'd7) begin
            return 7'd2;
        end else if (duty < 9'd10) begin
            return DEFAULT_CURRENT;
        end else if (duty <= 9'd85) begin
            // duty * 6 / 10 == (duty * 3) / 5
            return 7'(p[16:10]);
        end else if (duty <= 9'd96) begin
            // (duty - 64) * 25 / 10 == (duty - 64) * 5 / 2
            return 7'(b[7:1]);
        end else if (duty == 9'd97) begin
            return TOP_CURRENT;
        end else begin
            return '0;
        end
    endfunction

endpackage

>>> hw/rtl/cppwm_div.sv
// Bit-serial restoring divider for the duty computation, one quotient bit per cycle.
module cppwm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cppwm_pkg::t_div_req  i_req,
    output cppwm_pkg::t_div_stat o_stat
);
    import cppwm_pkg::*;

    logic [W_NUM-1:0] r_num;
    logic [W_PER-1:0] r_den;
    logic [W_PER-1:0] r_rem;
    logic [W_QUO-1:0] r_quo;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W_PER:0]   w_trial;
    logic [W_PER:0]   w_diff;
    logic             w_ge;

    // one trial subtract per cycle
    assign w_trial = {r_rem, r_num[W_NUM-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[W_NUM-2:0], 1'b0};
                r_rem <= w_ge ? w_diff[W_PER-1:0] : w_trial[W_PER-1:0];
                // quotient is known to fit; upper bits shifted out are zero
                r_quo <= {r_quo[W_QUO-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(W_NUM - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_quo;

endmodule

>>> hw/rtl/control_pilot_pwm_current_decoder_unit.sv
// Control pilot PWM decoder: duty of the pilot signal to allowed charging current.
// Wrap ticks go straight to commit; falling edges run the multiply and evaluate, then commit.
// Rising edge: bit-serial wrap_count * 1000 multiply, evaluate and check, bit-serial duty
// divider, commit. One request at a time; the next is taken the cycle after the result
// is registered.
// Synchronous active-low reset: current 6 A, timeout 500 wraps, counters and times zero.
module control_pilot_pwm_current_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cppwm_pkg::t_in_req            i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cppwm_pkg::t_out_req           o_out_req,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cppwm_pkg::W_WRAP-1:0]  i_cfg_data
);
    import cppwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EVAL,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state;
    t_in_req           r_item;
    logic [W_WRAP-1:0] r_timeout;
    logic [W_WRAP-1:0] r_wrap_cnt;
    logic [W_TIME-1:0] r_rise;
    logic [W_FALL-1:0] r_fall;
    logic              r_fall_vld;
    logic [W_CUR-1:0]  r_cur;
    logic [W_WRAP-1:0] r_wrap_sh;
    logic [W_FALL-1:0] r_acc;
    logic [3:0]        r_step;
    logic [W_FALL-1:0] r_now;
    logic [W_FALL:0]   r_dif;
    logic              r_upd;
    logic [W_CUR-1:0]  r_new_cur;
    logic              r_out_valid;
    t_out_req          r_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_commit;
    logic [W_FALL-1:0] w_mul_add;
    logic [W_FALL-1:0] n_acc;
    logic [W_FALL-1:0] w_period;
    logic              w_now_ok;
    logic              w_dif_ok;
    logic              w_per_ok;
    logic              w_go;
    logic              w_timeout_hit;
    logic [W_CUR-1:0]  n_cur;
    t_div_req          w_div_req;
    t_div_stat         w_div_stat;

    // handshakes
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_state != S_IDLE;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_commit    = (r_state == S_FIN) && w_out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // serial multiply: MSB-first shift-add of wrap_count * 1000
    assign w_mul_add = r_wrap_sh[W_WRAP-1] ? W_FALL'(WRAP_COUNTS) : '0;
    assign n_acc     = {r_acc[W_FALL-2:0], 1'b0} + w_mul_add;

    // rising edge checks: period window, fall present and not before rise
    assign w_now_ok = r_now >= W_FALL'(r_rise);
    assign w_period = r_now - W_FALL'(r_rise);
    assign w_per_ok = (w_period > W_FALL'(PERIOD_MIN_EXCL)) &&
                      (w_period <= W_FALL'(PERIOD_MAX));
    // high time of 4096 or more always gives a duty above 100
    assign w_dif_ok = !r_dif[W_FALL] && (r_dif[W_FALL-1:12] == '0);
    assign w_go     = r_fall_vld && w_now_ok && w_dif_ok && w_per_ok;

    assign w_div_req.start = (r_state == S_CHK) && w_go;
    assign w_div_req.num   = W_NUM'(r_dif[11:0]) * W_NUM'(DUTY_SCALE);
    assign w_div_req.den   = w_period[W_PER-1:0];

    cppwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    // current after this request
    assign w_timeout_hit = r_wrap_cnt > r_timeout;
    always_comb begin
        n_cur = r_cur;
        if (!r_item.operation) begin
            if (w_timeout_hit) begin
                n_cur = '0;
            end
        end else if (r_item.pin_level && r_upd) begin
            n_cur = r_new_cur;
        end
    end

    // sequencer, decoder state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_wrap_cnt  <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_fall_vld  <= 1'b0;
            r_cur       <= DEFAULT_CURRENT;
            r_out_valid <= 1'b0;
            r_upd       <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            // output register fills on commit, empties when taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item    <= i_in_req;
                        r_upd     <= 1'b0;
                        r_wrap_sh <= r_wrap_cnt;
                        r_acc     <= '0;
                        r_step    <= '0;
                        r_state   <= i_in_req.operation ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_acc     <= n_acc;
                    r_wrap_sh <= {r_wrap_sh[W_WRAP-2:0], 1'b0};
                    r_step    <= r_step + 4'd1;
                    if (r_step == 4'(W_WRAP - 1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_now   <= r_acc + W_FALL'(r_item.capture_time);
                    r_dif   <= {1'b0, r_fall} - (W_FALL+1)'(r_rise);
                    r_state <= r_item.pin_level ? S_CHK : S_FIN;
                end
                S_CHK: begin
                    r_state <= w_go ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_upd     <= w_div_stat.quotient <= W_QUO'(DUTY_SCALE);
                        r_new_cur <= duty_to_current(w_div_stat.quotient);
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_cur                     <= n_cur;
                        r_out.amp_limit           <= n_cur;
                        r_out.current_changed     <= n_cur != r_cur;
                        r_state                   <= S_IDLE;
                        if (!r_item.operation) begin
                            r_wrap_cnt <= w_timeout_hit ? '0 : r_wrap_cnt + 16'd1;
                        end else if (!r_item.pin_level) begin
                            r_fall     <= r_now;
                            r_fall_vld <= 1'b1;
                        end else begin
                            r_wrap_cnt <= '0;
                            r_rise     <= r_item.capture_time;
                            r_fall     <= '0;
                            r_fall_vld <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == S_DIV)
        else $error("divider done outside of divide state");

    // wrap ticks never enter the multiply
    a_mul_edges_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_item.operation)
        else $error("wrap tick in multiply state");

    // reported current tracks the stored current
    a_out_matches_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_req.amp_limit == r_cur)
        else $error("output current differs from stored current");

    // current never exceeds the top band
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.amp_limit <= TOP_CURRENT)
        else $error("current above maximum");

endmodule

>>> test/cppwm_current_monitor.sv
// Monitor for the pilot PWM decoder: predicts each allowed current and checks the results.
`timescale 1ns / 100ps

module cppwm_current_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  cppwm_pkg::t_in_req           i_in_req,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  cppwm_pkg::t_out_req          i_out_req,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [cppwm_pkg::W_WRAP-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import cppwm_pkg::*;

    localparam int   SHOW_LIMIT = 10;

    // predicted decoder state
    logic [W_WRAP-1:0] loss_wraps   = TIMEOUT_RESET;
    logic [W_WRAP-1:0] wraps_seen   = '0;
    logic [W_TIME-1:0] rise_stamp   = '0;
    logic [W_FALL-1:0] fall_stamp   = '0;
    logic              fall_seen    = 1'b0;
    logic [W_CUR-1:0]  amps         = DEFAULT_CURRENT;

    t_out_req          expected_amps[$];
    int                fails        = 0;

    // standard duty bands, duty in whole percent
    function automatic logic [W_CUR-1:0] band_current(input longint unsigned duty);
        if (duty <= 2) begin
            return '0;
        end else if (duty <= 7) begin
            return W_CUR'(2);
        end else if (duty <= 9) begin
            return DEFAULT_CURRENT;
        end else if (duty <= 85) begin
            return W_CUR'(duty * 6 / 10);
        end else if (duty <= 96) begin
            return W_CUR'((duty - BAND_OFFSET) * 25 / 10);
        end else if (duty == 97) begin
            return TOP_CURRENT;
        end
        return '0;
    endfunction

    // advance the predicted state by one request, give the result it causes
    task automatic predict_current(input t_in_req req, output t_out_req res);
        longint unsigned now_t;
        longint unsigned period;
        longint unsigned high_t;
        longint unsigned duty;
        logic [W_CUR-1:0] prev;
        prev = amps;
        if (req.operation == OP_WRAP) begin
            if (wraps_seen > loss_wraps) begin
                // pilot lost: drop the current
                wraps_seen = '0;
                amps       = '0;
            end else begin
                wraps_seen = wraps_seen + 1'b1;
            end
        end else if (req.pin_level == LEVEL_FALL) begin
            now_t      = longint'(wraps_seen) * WRAP_COUNTS + req.capture_time;
            fall_stamp = W_FALL'(now_t);
            fall_seen  = 1'b1;
        end else begin
            now_t = longint'(wraps_seen) * WRAP_COUNTS + req.capture_time;
            // no update on a negative period, a missing fall or a fall before the rise
            if (now_t >= rise_stamp && fall_seen && fall_stamp >= rise_stamp) begin
                period = now_t - rise_stamp;
                if (period > PERIOD_MIN_EXCL && period <= PERIOD_MAX) begin
                    high_t = fall_stamp - rise_stamp;
                    duty   = high_t * DUTY_SCALE / period;
                    if (duty <= DUTY_SCALE) begin
                        amps = band_current(duty);
                    end
                end
            end
            wraps_seen = '0;
            rise_stamp = req.capture_time;
            fall_stamp = '0;
            fall_seen  = 1'b0;
        end
        res.amp_limit       = amps;
        res.current_changed = (amps != prev);
    endtask

    // watch the channels; results are checked before the new request is queued
    always @(posedge i_clk) begin : watch
        t_out_req want;
        if (!i_rst_n) begin
            loss_wraps = TIMEOUT_RESET;
            wraps_seen = '0;
            rise_stamp = '0;
            fall_stamp = '0;
            fall_seen  = 1'b0;
            amps       = DEFAULT_CURRENT;
            expected_amps.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                loss_wraps = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_amps.size() == 0) begin
                    fails++;
                    if (fails <= SHOW_LIMIT) begin
                        $display("%0t: result with no request waiting: amp_limit %0d changed %0b",
                                 $time, i_out_req.amp_limit, i_out_req.current_changed);
                    end
                end else begin
                    want = expected_amps.pop_front();
                    if (want.amp_limit !== i_out_req.amp_limit ||
                        want.current_changed !== i_out_req.current_changed) begin
                        fails++;
                        if (fails <= SHOW_LIMIT) begin
                            $display("%0t: amp_limit exp %0d got %0d, changed exp %0b got %0b",
                                     $time, want.amp_limit, i_out_req.amp_limit,
                                     want.current_changed, i_out_req.current_changed);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_current(i_in_req, want);
                expected_amps.push_back(want);
            end
        end
        o_pending    <= expected_amps.size();
        o_fail_count <= fails;
    end

endmodule

>>> test/control_pilot_pwm_current_decoder_unit_test.sv
// Testbench top for the pilot PWM decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module control_pilot_pwm_current_decoder_unit_test;
    import cppwm_pkg::*;

    localparam int   CLK_HALF      = 5;
    localparam int   RESET_CYCLES  = 8;
    localparam int   SETTLE_CYCLES = 45;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   LONG_HOLD     = 400;
    localparam int   PHASE_ITEMS   = 230;
    localparam int   SHORT_LOSS    = 20;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_req           in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_req          out_req;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [W_WRAP-1:0] cfg_data  = '0;
    int                fail_count;
    int                pending;

    // idle shaping and the long receiver hold-off
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_asked    = 0;
    int                hold_served   = 0;
    int                hold_left     = 0;
    int                cycles        = 0;

    // stimulus bookkeeping
    int                sent          = 0;
    int unsigned       cur_timeout   = TIMEOUT_RESET;
    bit                chained       = 1'b0;
    int unsigned       last_rise     = 0;

    control_pilot_pwm_current_decoder_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    cppwm_current_monitor u_current_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            out_stall   <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic t_in_req wrap_req();
        t_in_req r;
        r.operation    = OP_WRAP;
        r.capture_time = W_TIME'($urandom_range(0, 1023));
        r.pin_level    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_in_req edge_req(input logic level, input int unsigned t);
        t_in_req r;
        r.operation    = OP_EDGE;
        r.capture_time = W_TIME'(t);
        r.pin_level    = level;
        return r;
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // offer one request and hold it until taken
    task automatic send(input t_in_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [W_WRAP-1:0] wraps);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= wraps;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        cur_timeout  = wraps;
    endtask

    // one pilot period: optional opening rise, wraps with an optional fall among them, closing rise
    task automatic pwm_cycle(input int unsigned period, input int unsigned high,
                             input bit with_fall);
        int unsigned r;
        int unsigned k;
        int unsigned fall_abs;
        int unsigned rise_abs;
        if (!chained) begin
            r = $urandom_range(0, 1023);
            send(edge_req(LEVEL_RISE, r));
        end else begin
            r = last_rise;
        end
        fall_abs = r + high;
        rise_abs = r + period;
        k = 0;
        if (with_fall) begin
            while (fall_abs >= (k + 1) * 1000) begin
                send(wrap_req());
                k++;
            end
            send(edge_req(LEVEL_FALL, fall_abs - k * 1000));
        end
        while (rise_abs >= (k + 1) * 1000) begin
            send(wrap_req());
            k++;
        end
        last_rise = rise_abs - k * 1000;
        send(edge_req(LEVEL_RISE, last_rise));
        chained = 1'b1;
    endtask

    // a fall recorded before a loss of pilot, then a rise one wrap later
    task automatic stale_fall();
        int unsigned r;
        int unsigned k;
        int signed   t;
        r = $urandom_range(100, 900);
        k = $urandom_range(1, cur_timeout + 1);
        send(edge_req(LEVEL_RISE, r));
        repeat (k) send(wrap_req());
        send(edge_req(LEVEL_FALL, $urandom_range(0, 999)));
        repeat (cur_timeout + 2 - k) send(wrap_req());
        send(wrap_req());
        t = int'(r) + $urandom_range(0, 199) - 99;
        send(edge_req(LEVEL_RISE, t));
        last_rise = t;
        chained   = 1'b1;
    endtask

    task automatic random_requests(input int n_items);
        int          start;
        int unsigned pick;
        int unsigned period;
        int unsigned high;
        start = sent;
        while (sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 9) == 0) begin
                    period = $urandom_range(0, 1) ? $urandom_range(850, 900)
                                                  : $urandom_range(1101, 1200);
                end else begin
                    period = $urandom_range(901, 1100);
                end
                high = $urandom_range(0, 100) * period / 100 + $urandom_range(0, 2);
                if (high > period) high = period;
                pwm_cycle(period, high, $urandom_range(0, 19) != 0);
            end else if (pick < 85) begin
                // loss of pilot under a short timeout, else three wraps only
                if (cur_timeout <= SHORT_LOSS) begin
                    repeat (cur_timeout + 2 + $urandom_range(0, 2)) send(wrap_req());
                end else begin
                    repeat (3) send(wrap_req());
                end
                chained = 1'b0;
            end else if (pick < 90 && cur_timeout <= SHORT_LOSS) begin
                stale_fall();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send(edge_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023)));
                    if ($urandom_range(0, 1)) send(wrap_req());
                end
                chained = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(10, 52);

        // directed: bands, special cases, field extremes
        send(edge_req(LEVEL_RISE, 100));        // missing fall
        send(edge_req(LEVEL_FALL, 600));
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));        // 50 % -> 30 A
        send(edge_req(LEVEL_FALL, 1023));       // capture time past 999
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));        // 92 % -> 70 A
        send(edge_req(LEVEL_FALL, 102));
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));        // 0 % -> 0 A
        send(edge_req(LEVEL_FALL, 130));
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));        // 3 % -> 2 A
        send(wrap_req());
        send(edge_req(LEVEL_FALL, 70));
        send(edge_req(LEVEL_RISE, 100));        // 97 % -> 80 A
        send(wrap_req());
        send(edge_req(LEVEL_FALL, 100));
        send(edge_req(LEVEL_RISE, 100));        // 100 % -> 0 A
        send(edge_req(LEVEL_FALL, 0));          // fall before rise
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));
        send(edge_req(LEVEL_RISE, 900));
        send(edge_req(LEVEL_RISE, 100));        // negative period

        // duty above 100: stale fall survives a loss of pilot
        write_timeout(16'd1);
        send(edge_req(LEVEL_RISE, 100));
        send(wrap_req());
        send(wrap_req());
        send(edge_req(LEVEL_FALL, 500));
        send(wrap_req());
        send(wrap_req());
        send(edge_req(LEVEL_RISE, 100));
        chained   = 1'b1;
        last_rise = 100;

        random_requests(PHASE_ITEMS);
        write_timeout(16'd0);
        random_requests(PHASE_ITEMS);

        set_idle(52, 10);
        write_timeout(TIMEOUT_RESET);
        repeat (TIMEOUT_RESET + 3) send(wrap_req());
        chained = 1'b0;
        random_requests(PHASE_ITEMS);
        write_timeout(16'hFFFF);
        // long result hold-off while requests keep coming
        hold_asked <= hold_asked + 1;
        random_requests(PHASE_ITEMS);

        set_idle(0, 0);
        write_timeout(W_WRAP'($urandom_range(2, 12)));
        random_requests(PHASE_ITEMS / 2);
        drain();
        random_requests(PHASE_ITEMS / 2);
        write_timeout(W_WRAP'($urandom_range(0, 65535)));
        random_requests(PHASE_ITEMS);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cppwm_pkg.sv
hw/rtl/cppwm_div.sv
hw/rtl/control_pilot_pwm_current_decoder_unit.sv
test/cppwm_current_monitor.sv
test/control_pilot_pwm_current_decoder_unit_test.sv
